// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define UL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define UL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/uldst_pkg.sv =====
// types, constants and helper functions of the lens undistortion block
`default_nettype none
package uldst_pkg;

  localparam int WIDE_W    = 48;
  localparam int FRAC      = 28;
  localparam int PIX_W     = 18;
  localparam int PIX_SHIFT = 11;
  localparam int OUT_W     = 32;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // divider: quotient of n * 2^(FRAC+1) / d, one bit per stage
  localparam int DIV_LANES = 2;
  localparam int DIV_QB    = WIDE_W + 1;
  localparam int DIV_SHIFT = FRAC + 1;
  localparam int DIV_PRE   = DIV_QB - DIV_SHIFT;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [WIDE_W+3:0] wsum_t;

  localparam wide_t WIDE_MAX = wide_t'(48'h7FFF_FFFF_FFFF);
  localparam wide_t Q_ONE    = wide_t'(48'h0000_1000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL = 3'd0,
    CFG_PP    = 3'd1,
    CFG_K1    = 3'd2,
    CFG_K2    = 3'd3,
    CFG_K3    = 3'd4,
    CFG_P1    = 3'd5,
    CFG_P2    = 3'd6
  } cfg_idx_e;

  // item context handed from cell to cell
  typedef struct packed {
    logic  done;
    logic  ov;
    logic  sx;
    logic  sy;
    wide_t xd;
    wide_t yd;
    wide_t x;
    wide_t y;
  } ctx_t;

  typedef struct packed {
    wide_t k1;
    wide_t k2;
    wide_t k3;
    wide_t p1;
    wide_t p2;
  } coef_t;

  typedef struct packed {
    wide_t val;
    logic  ov;
  } sat_t;

  function automatic sat_t sat48(input wsum_t v);
    sat_t r;
    r.val = v[WIDE_W-1:0];
    r.ov  = 1'b0;
    if (v > wsum_t'(WIDE_MAX)) begin
      r.val = WIDE_MAX;
      r.ov  = 1'b1;
    end else if (v < -wsum_t'(WIDE_MAX)) begin
      r.val = -WIDE_MAX;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [WIDE_W-1:0] mag48(input wide_t v);
    logic [WIDE_W-1:0] r;
    r = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uldst_if.sv =====
// handshake interfaces for the input, result and configuration channels
`default_nettype none
interface uldst_in_if;
  import uldst_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_u;
  logic [PIX_W-1:0] pixel_v;
  modport source (output valid, output pixel_u, output pixel_v, input ready);
  modport sink (input valid, input pixel_u, input pixel_v, output ready);
endinterface

interface uldst_out_if;
  import uldst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] norm_x;
  logic signed [OUT_W-1:0] norm_y;
  logic                    overflow;
  modport source (output valid, output norm_x, output norm_y, output overflow, input ready);
  modport sink (input valid, input norm_x, input norm_y, input overflow, output ready);
endinterface

interface uldst_cfg_if;
  import uldst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/uldst_mul.sv =====
// two-stage q28 multiplier with rounding and saturation
`default_nettype none
module uldst_mul (
  input  logic           clk_i,
  input  logic           en_i,
  input  uldst_pkg::wide_t a_i,
  input  uldst_pkg::wide_t b_i,
  output uldst_pkg::wide_t p_o,
  output logic           ov_o
);
  import uldst_pkg::*;

  localparam int HW = WIDE_W / 2;
  localparam int PW = 2 * WIDE_W;

  logic [WIDE_W-1:0] ma, mb;
  logic [HW-1:0]     al, ah, bl, bh;
  logic [WIDE_W-1:0] ll_q, lh_q, hl_q, hh_q;
  logic              neg_q;
  logic [PW-1:0]     full, rnd;
  logic [PW-FRAC-1:0] mag;
  logic              sat;
  wide_t             m47, p_d;

  assign ma = mag48(a_i);
  assign mb = mag48(b_i);
  assign al = ma[HW-1:0];
  assign ah = ma[WIDE_W-1:HW];
  assign bl = mb[HW-1:0];
  assign bh = mb[WIDE_W-1:HW];

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= al * bl;
      lh_q  <= al * bh;
      hl_q  <= ah * bl;
      hh_q  <= ah * bh;
      neg_q <= a_i[WIDE_W-1] ^ b_i[WIDE_W-1];
    end
  end

  always_comb begin
    full = PW'(ll_q) + (PW'(lh_q) << HW) + (PW'(hl_q) << HW) + (PW'(hh_q) << WIDE_W);
    rnd  = full + (PW'(1) << (FRAC - 1));
    mag  = rnd[PW-1:FRAC];
    sat  = mag > (PW-FRAC)'(WIDE_MAX);
    m47  = sat ? WIDE_MAX : wide_t'(mag[WIDE_W-1:0]);
    p_d  = neg_q ? -m47 : m47;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o  <= p_d;
      ov_o <= sat;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/uldst_div.sv =====
// pipelined two-lane q28 divider, one quotient bit per stage
`default_nettype none
module uldst_div #(
  parameter int PW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  uldst_pkg::wide_t num_i [uldst_pkg::DIV_LANES],
  input  uldst_pkg::wide_t den_i [uldst_pkg::DIV_LANES],
  input  logic [PW-1:0]    pay_i,
  output logic             vld_o,
  output uldst_pkg::wide_t quo_o [uldst_pkg::DIV_LANES],
  output logic             ov_o [uldst_pkg::DIV_LANES],
  output logic [PW-1:0]    pay_o
);
  import uldst_pkg::*;

  localparam int QB = DIV_QB;

  logic [QB+1:0] vld_q;
  logic [PW-1:0] pay_q [0:QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= pay_i;
      for (int k = 1; k <= QB + 1; k++) pay_q[k] <= pay_q[k-1];
    end
  end

  assign vld_o = vld_q[QB+1];
  assign pay_o = pay_q[QB+1];

  for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
    logic [WIDE_W-1:0] rem_q [0:QB-1];
    logic [QB-1:0]     q_q   [0:QB];
    logic [WIDE_W-1:0] m_q   [0:DIV_PRE-1];
    logic [WIDE_W-1:0] d_q   [0:QB-1];
    logic              neg_q [0:QB];
    logic              sat_q [0:QB];
    logic [WIDE_W-1:0] mag0, ud0;
    logic              dpos, big;
    logic [QB:0]       qinc;
    logic [QB-1:0]     qr;
    logic              osat;
    wide_t             omag;

    // operand setup and range check: quotient must fit QB bits
    always_comb begin
      mag0 = mag48(num_i[l]);
      ud0  = den_i[l];
      dpos = den_i[l] > wide_t'(0);
      big  = {{DIV_PRE{1'b0}}, mag0} >= {ud0, {DIV_PRE{1'b0}}};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= mag0 >> DIV_PRE;
        q_q[0]   <= '0;
        m_q[0]   <= mag0;
        d_q[0]   <= ud0;
        neg_q[0] <= num_i[l][WIDE_W-1];
        sat_q[0] <= !dpos || big;
      end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_bit
      localparam int BI = QB - k;
      logic          nbit;
      logic [WIDE_W:0] t, diff;
      logic          ge;

      if (BI >= DIV_SHIFT) begin : g_nb
        assign nbit = m_q[k-1][BI-DIV_SHIFT];
      end else begin : g_nz
        assign nbit = 1'b0;
      end

      assign t    = {rem_q[k-1], nbit};
      assign ge   = t >= {1'b0, d_q[k-1]};
      assign diff = t - {1'b0, d_q[k-1]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          q_q[k]   <= {q_q[k-1][QB-2:0], ge};
          neg_q[k] <= neg_q[k-1];
          sat_q[k] <= sat_q[k-1];
        end
      end

      if (k < QB) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[k] <= ge ? diff[WIDE_W-1:0] : t[WIDE_W-1:0];
            d_q[k]   <= d_q[k-1];
          end
        end
      end

      if (k < DIV_PRE) begin : g_num
        always_ff @(posedge clk_i) begin
          if (en_i) m_q[k] <= m_q[k-1];
        end
      end
    end

    // round half away from zero: (floor(2n/d) + 1) / 2
    always_comb begin
      qinc = {1'b0, q_q[QB]} + (QB+1)'(1);
      qr   = qinc[QB:1];
      osat = sat_q[QB] || (qr > {1'b0, WIDE_MAX});
      omag = osat ? WIDE_MAX : wide_t'(qr[WIDE_W-1:0]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_o[l] <= neg_q[QB] ? -omag : omag;
        ov_o[l]  <= osat;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/uldst_cell.sv =====
// one undistortion iteration: radial and tangential terms, then the divide
`default_nettype none
module uldst_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  uldst_pkg::coef_t  coef_i,
  input  logic              vld_i,
  input  uldst_pkg::ctx_t   ctx_i,
  output logic              vld_o,
  output uldst_pkg::ctx_t   ctx_o
);
  import uldst_pkg::*;

  localparam int NS = 10;

  logic [NS:1] vld_q;
  ctx_t        c_q  [1:NS];
  logic        fl_q [3:NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[1] <= ctx_i;
      for (int j = 2; j <= NS; j++) c_q[j] <= c_q[j-1];
    end
  end

  // squares and cross product
  wide_t x2, y2, xy;
  logic  x2_ov, y2_ov, xy_ov;
  uldst_mul u_x2 (.clk_i, .en_i, .a_i(ctx_i.x), .b_i(ctx_i.x), .p_o(x2), .ov_o(x2_ov));
  uldst_mul u_y2 (.clk_i, .en_i, .a_i(ctx_i.y), .b_i(ctx_i.y), .p_o(y2), .ov_o(y2_ov));
  uldst_mul u_xy (.clk_i, .en_i, .a_i(ctx_i.x), .b_i(ctx_i.y), .p_o(xy), .ov_o(xy_ov));

  sat_t  s_r2, s_a1, s_a2, s_a3, s_dx, s_dy, s_nx, s_ny, s_kr;
  wide_t r2_3_q, r2_4_q, r2_5_q, a1_3_q, a1_4_q, a2_4_q, a3_4_q, x2_3_q, y2_3_q;
  wide_t dx_7_q, dy_7_q, nx_8_q, ny_8_q, nx_9_q, ny_9_q, nx_10_q, ny_10_q;
  wide_t k1r2_6_q, k1r2_7_q, k1r2_8_q, k1r2_9_q, k2r4_8_q, k2r4_9_q, kr_10_q;

  wide_t r4, k1r2, r6, k2r4, k3r6, pa1, pb1, pa2, pb2;
  logic  r4_ov, k1r2_ov, r6_ov, k2r4_ov, k3r6_ov, pa1_ov, pb1_ov, pa2_ov, pb2_ov;

  uldst_mul u_r4   (.clk_i, .en_i, .a_i(r2_3_q), .b_i(r2_3_q), .p_o(r4), .ov_o(r4_ov));
  uldst_mul u_k1r2 (.clk_i, .en_i, .a_i(coef_i.k1), .b_i(r2_3_q), .p_o(k1r2), .ov_o(k1r2_ov));
  uldst_mul u_pa1  (.clk_i, .en_i, .a_i(coef_i.p1), .b_i(a1_4_q), .p_o(pa1), .ov_o(pa1_ov));
  uldst_mul u_pb1  (.clk_i, .en_i, .a_i(coef_i.p2), .b_i(a2_4_q), .p_o(pb1), .ov_o(pb1_ov));
  uldst_mul u_pa2  (.clk_i, .en_i, .a_i(coef_i.p2), .b_i(a1_4_q), .p_o(pa2), .ov_o(pa2_ov));
  uldst_mul u_pb2  (.clk_i, .en_i, .a_i(coef_i.p1), .b_i(a3_4_q), .p_o(pb2), .ov_o(pb2_ov));
  uldst_mul u_r6   (.clk_i, .en_i, .a_i(r4), .b_i(r2_5_q), .p_o(r6), .ov_o(r6_ov));
  uldst_mul u_k2r4 (.clk_i, .en_i, .a_i(coef_i.k2), .b_i(r4), .p_o(k2r4), .ov_o(k2r4_ov));
  uldst_mul u_k3r6 (.clk_i, .en_i, .a_i(coef_i.k3), .b_i(r6), .p_o(k3r6), .ov_o(k3r6_ov));

  always_comb begin
    s_r2 = sat48(wsum_t'(x2) + wsum_t'(y2));
    s_a1 = sat48(wsum_t'(xy) + wsum_t'(xy));
    s_a2 = sat48(wsum_t'(r2_3_q) + wsum_t'(x2_3_q) + wsum_t'(x2_3_q));
    s_a3 = sat48(wsum_t'(r2_3_q) + wsum_t'(y2_3_q) + wsum_t'(y2_3_q));
    s_dx = sat48(wsum_t'(pa1) + wsum_t'(pb1));
    s_dy = sat48(wsum_t'(pa2) + wsum_t'(pb2));
    s_nx = sat48(wsum_t'(c_q[7].xd) - wsum_t'(dx_7_q));
    s_ny = sat48(wsum_t'(c_q[7].yd) - wsum_t'(dy_7_q));
    s_kr = sat48(wsum_t'(Q_ONE) + wsum_t'(k1r2_9_q) + wsum_t'(k2r4_9_q) + wsum_t'(k3r6));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_3_q   <= s_r2.val;
      a1_3_q   <= s_a1.val;
      x2_3_q   <= x2;
      y2_3_q   <= y2;
      r2_4_q   <= r2_3_q;
      a1_4_q   <= a1_3_q;
      a2_4_q   <= s_a2.val;
      a3_4_q   <= s_a3.val;
      r2_5_q   <= r2_4_q;
      k1r2_6_q <= k1r2;
      k1r2_7_q <= k1r2_6_q;
      k1r2_8_q <= k1r2_7_q;
      k1r2_9_q <= k1r2_8_q;
      dx_7_q   <= s_dx.val;
      dy_7_q   <= s_dy.val;
      nx_8_q   <= s_nx.val;
      ny_8_q   <= s_ny.val;
      nx_9_q   <= nx_8_q;
      ny_9_q   <= ny_8_q;
      nx_10_q  <= nx_9_q;
      ny_10_q  <= ny_9_q;
      k2r4_8_q <= k2r4;
      k2r4_9_q <= k2r4_8_q;
      kr_10_q  <= s_kr.val;
      // saturation flags gathered along the way
      fl_q[3]  <= x2_ov | y2_ov | xy_ov | s_r2.ov | s_a1.ov;
      fl_q[4]  <= fl_q[3] | s_a2.ov | s_a3.ov;
      fl_q[5]  <= fl_q[4];
      fl_q[6]  <= fl_q[5] | r4_ov | k1r2_ov;
      fl_q[7]  <= fl_q[6] | pa1_ov | pb1_ov | pa2_ov | pb2_ov | s_dx.ov | s_dy.ov;
      fl_q[8]  <= fl_q[7] | s_nx.ov | s_ny.ov | r6_ov | k2r4_ov;
      fl_q[9]  <= fl_q[8];
      fl_q[10] <= fl_q[9] | k3r6_ov | s_kr.ov;
    end
  end

  // non-positive radial factor ends the item with signed saturation
  wide_t dnum [DIV_LANES];
  wide_t dden [DIV_LANES];
  wide_t dquo [DIV_LANES];
  logic  dov  [DIV_LANES];
  ctx_t  dpay_in, dpay_out;

  always_comb begin
    dnum[0] = nx_10_q;
    dnum[1] = ny_10_q;
    dden[0] = kr_10_q;
    dden[1] = kr_10_q;
    dpay_in    = c_q[NS];
    dpay_in.ov = c_q[NS].ov | fl_q[NS];
    if (!c_q[NS].done && !(kr_10_q > wide_t'(0))) begin
      dpay_in.done = 1'b1;
      dpay_in.sx   = nx_10_q[WIDE_W-1];
      dpay_in.sy   = ny_10_q[WIDE_W-1];
    end
  end

  uldst_div #(.PW($bits(ctx_t))) u_div (
    .clk_i, .rst_ni, .en_i,
    .vld_i(vld_q[NS]), .num_i(dnum), .den_i(dden), .pay_i(dpay_in),
    .vld_o, .quo_o(dquo), .ov_o(dov), .pay_o(dpay_out)
  );

  always_comb begin
    ctx_o    = dpay_out;
    ctx_o.x  = dquo[0];
    ctx_o.y  = dquo[1];
    ctx_o.ov = dpay_out.ov | dov[0] | dov[1];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/iterative_lens_undistort_top.sv =====
// top level of the iterative lens undistortion pipeline
// usage:
//   in_if carries one distorted pixel (pixel_u, pixel_v, unsigned q13.5) per item.
//   out_if returns norm_x, norm_y (signed q4.28) and overflow for every item,
//   in input order.
//   cfg_if writes one register per transfer: 0 focal lengths, 1 principal point,
//   2..6 k1, k2, k3, p1, p2; it is always ready and should be written while idle.
// pipeline: a 51-stage normalizing divider, then ITERATIONS (default 20) cells of 10
//   multiply/add stages and a 51-stage bit-per-stage divider, then the output register.
// throughput: one item per cycle unless a held output stalls the pipeline; every cell stage holds a different item.
// reset clears all valid bits and loads the register defaults (fx = fy = 1.0,
//   everything else zero); no item is in flight afterwards.
// stall: when the output register holds an item and out_if.ready is low the
//   whole pipeline freezes and in_if.ready drops in the same cycle.
`default_nettype none
module iterative_lens_undistort_top #(
  parameter int ITERATIONS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uldst_in_if.sink   in_if,
  uldst_out_if.source out_if,
  uldst_cfg_if.sink  cfg_if
);
  import uldst_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]  focal_q, pp_q;
  logic [COEF_W-1:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= 64'h0001_0000_0001_0000;
      pp_q    <= '0;
      k1_q    <= '0;
      k2_q    <= '0;
      k3_q    <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_e'(cfg_if.index))
        CFG_FOCAL: focal_q <= cfg_if.data;
        CFG_PP:    pp_q    <= cfg_if.data;
        CFG_K1:    k1_q    <= cfg_if.data[COEF_W-1:0];
        CFG_K2:    k2_q    <= cfg_if.data[COEF_W-1:0];
        CFG_K3:    k3_q    <= cfg_if.data[COEF_W-1:0];
        CFG_P1:    p1_q    <= cfg_if.data[COEF_W-1:0];
        CFG_P2:    p2_q    <= cfg_if.data[COEF_W-1:0];
        default:   ;
      endcase
    end
  end

  // coefficients sign-extended to the working width
  coef_t coef;
  assign coef.k1 = wide_t'($signed(k1_q));
  assign coef.k2 = wide_t'($signed(k2_q));
  assign coef.k3 = wide_t'($signed(k3_q));
  assign coef.p1 = wide_t'($signed(p1_q));
  assign coef.p2 = wide_t'($signed(p2_q));

  // the whole chain moves together unless a finished item is held at the output
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // normalization: (pixel << 11 - c) * 2^28 / f
  wide_t nnum [DIV_LANES];
  wide_t nden [DIV_LANES];
  wide_t nquo [DIV_LANES];
  logic  nov  [DIV_LANES];
  ctx_t  npay_in, npay_out;
  logic  nvld;

  always_comb begin
    nnum[0] = wide_t'({in_if.pixel_u, {PIX_SHIFT{1'b0}}}) - wide_t'(pp_q[CFG_W/2-1:0]);
    nnum[1] = wide_t'({in_if.pixel_v, {PIX_SHIFT{1'b0}}}) - wide_t'(pp_q[CFG_W-1:CFG_W/2]);
    nden[0] = wide_t'(focal_q[CFG_W/2-1:0]);
    nden[1] = wide_t'(focal_q[CFG_W-1:CFG_W/2]);
    npay_in = '0;
  end

  uldst_div #(.PW($bits(ctx_t))) u_norm (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(in_if.valid), .num_i(nnum), .den_i(nden), .pay_i(npay_in),
    .vld_o(nvld), .quo_o(nquo), .ov_o(nov), .pay_o(npay_out)
  );

  // chain of iteration cells
  ctx_t link     [0:ITERATIONS];
  logic link_vld [0:ITERATIONS];

  always_comb begin
    link[0]    = npay_out;
    link[0].xd = nquo[0];
    link[0].x  = nquo[0];
    link[0].yd = nquo[1];
    link[0].y  = nquo[1];
    link[0].ov = nov[0] | nov[1];
  end
  assign link_vld[0] = nvld;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    uldst_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .coef_i(coef),
      .vld_i(link_vld[i]), .ctx_i(link[i]),
      .vld_o(link_vld[i+1]), .ctx_o(link[i+1])
    );
  end

  // final 32-bit saturation, or the early-exit result
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  ctx_t                    last;
  logic signed [OUT_W-1:0] nx_d, ny_d;
  logic                    ov_d;

  always_comb begin
    last = link[ITERATIONS];
    ov_d = last.ov;
    if (last.done) begin
      nx_d = last.sx ? OUT_MIN : OUT_MAX;
      ny_d = last.sy ? OUT_MIN : OUT_MAX;
      ov_d = 1'b1;
    end else begin
      nx_d = last.x[OUT_W-1:0];
      ny_d = last.y[OUT_W-1:0];
      if (last.x > wide_t'(OUT_MAX)) begin
        nx_d = OUT_MAX;
        ov_d = 1'b1;
      end else if (last.x < wide_t'(OUT_MIN)) begin
        nx_d = OUT_MIN;
        ov_d = 1'b1;
      end
      if (last.y > wide_t'(OUT_MAX)) begin
        ny_d = OUT_MAX;
        ov_d = 1'b1;
      end else if (last.y < wide_t'(OUT_MIN)) begin
        ny_d = OUT_MIN;
        ov_d = 1'b1;
      end
    end
  end

  // output register
  logic signed [OUT_W-1:0] nx_q, ny_q;
  logic                    ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= link_vld[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      ov_q <= ov_d;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.norm_x   = nx_q;
  assign out_if.norm_y   = ny_q;
  assign out_if.overflow = ov_q;
endmodule
`default_nettype wire

// ===== hw/rtl/uldst_checker.sv =====
// port-level checker for the lens undistortion top level, with its bind
`default_nettype none
`include "assert_macros.svh"
module uldst_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [uldst_pkg::OUT_W-1:0]    norm_x_i,
  input logic signed [uldst_pkg::OUT_W-1:0]    norm_y_i,
  input logic                                  overflow_i
);
  // held item stays offered
  `UL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // held item keeps its fields
  `UL_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(norm_x_i) && $stable(norm_y_i) && $stable(overflow_i))
  // an empty output register never blocks the input
  `UL_ASSERT_NOW(a_in_free, !out_valid_i, in_ready_i)
  // a stalled output freezes the whole chain, input included
  `UL_ASSERT_NOW(a_in_stall, out_valid_i && !out_ready_i, !in_ready_i && !(in_valid_i && in_ready_i))
endmodule

bind iterative_lens_undistort_top uldst_checker u_uldst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .norm_x_i    (out_if.norm_x),
  .norm_y_i    (out_if.norm_y),
  .overflow_i  (out_if.overflow)
);
`default_nettype wire

// ===== tb/tb_iterative_lens_undistort_top.sv =====
// testbench of the iterative lens undistortion top level
`timescale 1ns / 1ps
`default_nettype none
module tb_iterative_lens_undistort_top;
  import uldst_pkg::*;

  localparam longint SAT_W = 64'sh7FFF_FFFF_FFFF; // symmetric 48-bit saturation bound
  localparam longint ONE_Q = 64'sh1000_0000;      // 1.0 in q28
  localparam int     STEPS = 20;                  // iteration count of the dut
  localparam int     DRAIN = 1300;                // cycles past the pipeline latency

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    ov;
  } point_t;

  logic clk_i;
  logic rst_ni;

  uldst_in_if  pix_bus ();
  uldst_out_if pt_bus ();
  uldst_cfg_if cfg_bus ();

  iterative_lens_undistort_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (pix_bus),
    .out_if (pt_bus),
    .cfg_if (cfg_bus)
  );

  // shadow copy of the lens registers used by the predictor
  logic [CFG_W-1:0]        focal_r;
  logic [CFG_W-1:0]        center_r;
  logic signed [COEF_W-1:0] coef_r [5];

  point_t expected_points[$];
  int     errors;
  bit     offering;     // pixel valid currently high
  int     burst_left;
  int     max_gap;      // longest sender gap for the current test
  int     stall_pct;    // receiver stall rate in percent
  int     hold_cycles;  // long receiver hold-off, counted down by the receiver process

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------

  // clamp to the symmetric 48-bit range, flag on clip
  function automatic longint clip48(input longint v, inout bit ov);
    if (v > SAT_W) begin
      ov = 1'b1;
      return SAT_W;
    end
    if (v < -SAT_W) begin
      ov = 1'b1;
      return -SAT_W;
    end
    return v;
  endfunction

  // q28 product, rounded half away from zero
  function automatic longint q28_mul(input longint a, input longint b, inout bit ov);
    logic [127:0] prod;
    longint       mag;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    prod = {64'd0, (a < 0) ? -a : a} * {64'd0, (b < 0) ? -b : b};
    prod = (prod + (128'd1 << 27)) >> 28;
    if (prod > 128'(SAT_W)) begin
      ov  = 1'b1;
      mag = SAT_W;
    end else begin
      mag = longint'(prod[63:0]);
    end
    return neg ? -mag : mag;
  endfunction

  // n * 2^28 / d, rounded half away from zero; non-positive d saturates
  function automatic longint q28_div(input longint n, input longint d, inout bit ov);
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    longint       mag;
    bit           neg;
    neg = n < 0;
    if (d <= 0) begin
      ov = 1'b1;
      return neg ? -SAT_W : SAT_W;
    end
    num = {64'd0, neg ? -n : n} << 28;
    quo = num / 128'(d);
    rem = num % 128'(d);
    if (2 * rem >= 128'(d)) quo = quo + 1;
    if (quo > 128'(SAT_W)) begin
      ov  = 1'b1;
      mag = SAT_W;
    end else begin
      mag = longint'(quo[63:0]);
    end
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q4_28(input longint v, inout bit ov);
    if (v > 64'sh7FFF_FFFF) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return v[OUT_W-1:0];
  endfunction

  // undistorted normalized point of one distorted pixel
  function automatic point_t undistort_point(input logic [PIX_W-1:0] pu,
                                             input logic [PIX_W-1:0] pv);
    point_t res;
    bit     ov;
    longint k1, k2, k3, p1, p2;
    longint xd, yd, x, y;
    longint x2, y2, xy, r2, r4, r6, kr, a1, a2, a3, dx, dy, nx, ny;
    ov = 1'b0;
    k1 = coef_r[0];
    k2 = coef_r[1];
    k3 = coef_r[2];
    p1 = coef_r[3];
    p2 = coef_r[4];
    xd = q28_div((longint'(pu) << PIX_SHIFT) - longint'(center_r[31:0]),
                 longint'(focal_r[31:0]), ov);
    yd = q28_div((longint'(pv) << PIX_SHIFT) - longint'(center_r[63:32]),
                 longint'(focal_r[63:32]), ov);
    x = xd;
    y = yd;
    for (int it = 0; it < STEPS; it++) begin
      x2 = q28_mul(x, x, ov);
      y2 = q28_mul(y, y, ov);
      xy = q28_mul(x, y, ov);
      r2 = clip48(x2 + y2, ov);
      r4 = q28_mul(r2, r2, ov);
      r6 = q28_mul(r4, r2, ov);
      kr = clip48(ONE_Q + q28_mul(k1, r2, ov) + q28_mul(k2, r4, ov) + q28_mul(k3, r6, ov), ov);
      a1 = clip48(2 * xy, ov);
      a2 = clip48(r2 + 2 * x2, ov);
      a3 = clip48(r2 + 2 * y2, ov);
      dx = clip48(q28_mul(p1, a1, ov) + q28_mul(p2, a2, ov), ov);
      dy = clip48(q28_mul(p2, a1, ov) + q28_mul(p1, a3, ov), ov);
      nx = clip48(xd - dx, ov);
      ny = clip48(yd - dy, ov);
      // radial factor collapsed: saturate by numerator sign and stop
      if (kr <= 0) begin
        res.x  = (nx < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        res.y  = (ny < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        res.ov = 1'b1;
        return res;
      end
      x = q28_div(nx, kr, ov);
      y = q28_div(ny, kr, ov);
    end
    res.x  = to_q4_28(x, ov);
    res.y  = to_q4_28(y, ov);
    res.ov = ov;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_FOCAL: focal_r  = value;
      CFG_PP:    center_r = value;
      CFG_K1:    coef_r[0] = value[31:0];
      CFG_K2:    coef_r[1] = value[31:0];
      CFG_K3:    coef_r[2] = value[31:0];
      CFG_P1:    coef_r[3] = value[31:0];
      default:   coef_r[4] = value[31:0];
    endcase
  endtask

  // offer one pixel, hold it until accepted, then maybe end the burst
  task automatic send_pixel(input logic [PIX_W-1:0] pu, input logic [PIX_W-1:0] pv);
    pix_bus.valid   <= 1'b1;
    pix_bus.pixel_u <= pu;
    pix_bus.pixel_v <= pv;
    offering = 1'b1;
    do @(posedge clk_i); while (!pix_bus.ready);
    expected_points.insert(expected_points.size(), undistort_point(pu, pv));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if (max_gap > 0) begin
        pix_bus.valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
      end
    end
  endtask

  // drop valid and wait for every point in flight to come back
  task automatic drain_points();
    if (offering) begin
      pix_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // receiver: stalls at random, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        pt_bus.ready <= 1'b0;
      end else begin
        pt_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // checker: compare each accepted point with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pt_bus.valid && pt_bus.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point", 0, 0);
      end else begin
        point_t want;
        want = expected_points.pop_front();
        if (pt_bus.norm_x !== want.x) report_mismatch("norm_x", pt_bus.norm_x, want.x);
        if (pt_bus.norm_y !== want.y) report_mismatch("norm_y", pt_bus.norm_y, want.y);
        if (pt_bus.overflow !== want.ov)
          report_mismatch("overflow", pt_bus.overflow, want.ov);
      end
    end
  end

  // ---------------------------------------------------------------------
  // configuration helpers
  // ---------------------------------------------------------------------

  // small q4.28 coefficient, magnitude up to the given fraction bits
  function automatic logic [CFG_W-1:0] small_coef(input int bits);
    int v;
    v = int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
    return CFG_W'($signed(v));
  endfunction

  // plausible camera: focal 100..2000 px, center anywhere in a 4k frame
  task automatic load_camera(input int coef_bits);
    write_reg(CFG_FOCAL, {16'($urandom_range(100, 2000)), 16'($urandom),
                          16'($urandom_range(100, 2000)), 16'($urandom)});
    write_reg(CFG_PP, {16'($urandom_range(0, 4000)), 16'($urandom),
                       16'($urandom_range(0, 4000)), 16'($urandom)});
    write_reg(CFG_K1, small_coef(coef_bits));
    write_reg(CFG_K2, small_coef(coef_bits));
    write_reg(CFG_K3, small_coef(coef_bits));
    write_reg(CFG_P1, small_coef(coef_bits - 4));
    write_reg(CFG_P2, small_coef(coef_bits - 4));
  endtask

  // mostly pixels inside a 4k frame, some anywhere in the field range
  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel(PIX_W'($urandom), PIX_W'($urandom));
      else
        send_pixel(PIX_W'($urandom_range(0, 4096 * 32)), PIX_W'($urandom_range(0, 4096 * 32)));
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // register defaults: unit focal length, so most points saturate
  task automatic test_reset_defaults();
    logic [PIX_W-1:0] corner [5] = '{18'd0, 18'h3FFFF, 18'd1, 18'h20000, 18'h1FFFF};
    max_gap   = 0;
    stall_pct = 0;
    foreach (corner[i]) send_pixel(corner[i], corner[4 - i]);
    drain_points();
  endtask

  // zero focal length: difference below, at and above the center
  task automatic test_zero_focal();
    write_reg(CFG_FOCAL, {32'd0, 32'd0});
    write_reg(CFG_PP, {32'd100 << 16, 32'd100 << 16});
    send_pixel(18'd100 << 5, 18'd100 << 5);
    send_pixel(18'd99 << 5, 18'd101 << 5);
    send_pixel(18'd101 << 5, 18'd0);
    drain_points();
    write_reg(CFG_FOCAL, {32'd500 << 16, 32'd0});
    send_pixel(18'd3, 18'd3000 << 5);
    drain_points();
  endtask

  // strongly negative k1: radial factor goes non-positive off center
  task automatic test_radial_collapse();
    write_reg(CFG_FOCAL, {32'd400 << 16, 32'd400 << 16});
    write_reg(CFG_PP, {32'd640 << 16, 32'd480 << 16});
    write_reg(CFG_K1, CFG_W'(32'h8000_0000));
    write_reg(CFG_K2, '0);
    write_reg(CFG_K3, '0);
    write_reg(CFG_P1, '0);
    write_reg(CFG_P2, '0);
    send_pixel(18'd640 << 5, 18'd480 << 5);   // center, r2 = 0
    send_pixel(18'd0, 18'd0);
    send_pixel(18'd1280 << 5, 18'd960 << 5);
    send_pixel(18'd0, 18'd960 << 5);
    send_pixel(18'd1280 << 5, 18'd0);
    send_pixel(18'd700 << 5, 18'd480 << 5);
    drain_points();
  endtask

  // extreme coefficients and registers at both ends of their range
  task automatic test_extreme_coefs();
    write_reg(CFG_FOCAL, '1);
    write_reg(CFG_PP, '1);
    write_reg(CFG_K1, CFG_W'(32'h7FFF_FFFF));
    write_reg(CFG_K2, CFG_W'(32'h8000_0000));
    write_reg(CFG_K3, CFG_W'(32'h7FFF_FFFF));
    write_reg(CFG_P1, CFG_W'(32'h8000_0000));
    write_reg(CFG_P2, CFG_W'(32'h7FFF_FFFF));
    send_pixel(18'h3FFFF, 18'h3FFFF);
    send_pixel(18'd0, 18'd0);
    drain_points();
    write_reg(CFG_FOCAL, {32'd1 << 16, 32'd1});
    write_reg(CFG_PP, '0);
    send_pixel(18'h3FFFF, 18'd1);
    send_pixel(18'd1, 18'h3FFFF);
    drain_points();
  endtask

  // random cameras and pixels with random gaps and stalls
  task automatic test_camera_random();
    for (int phase = 0; phase < 3; phase++) begin
      load_camera(phase == 2 ? 30 : 26);
      max_gap   = (phase == 1) ? 0 : 6;
      stall_pct = (phase == 0) ? 0 : 30;
      send_random_pixels(phase == 2 ? 60 : 100);
      drain_points();
    end
  endtask

  // receiver holds off far longer than the pipeline depth while pixels keep coming
  task automatic test_backpressure();
    load_camera(26);
    max_gap     = 0;
    stall_pct   = 10;
    burst_left  = 100000;
    hold_cycles = 2500;
    send_random_pixels(1300);
    burst_left = 1;
    drain_points();
  endtask

  initial begin
    errors        = 0;
    offering      = 1'b0;
    burst_left    = 1;
    max_gap       = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    focal_r       = 64'h0001_0000_0001_0000;
    center_r      = '0;
    foreach (coef_r[i]) coef_r[i] = '0;
    rst_ni          = 1'b0;
    pix_bus.valid   = 1'b0;
    pix_bus.pixel_u = '0;
    pix_bus.pixel_v = '0;
    pt_bus.ready    = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_FOCAL;
    cfg_bus.data    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_focal();
    test_radial_collapse();
    test_extreme_coefs();
    test_camera_random();
    test_backpressure();

    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
